// ----- hw/rtl/rle_expand_dequantize_top_defines.svh -----
// ----------------------------------------------------------------------------
// rle_expand_dequantize_top_defines.svh
// Assertion macros used by the run-length decoder's expander (rled_expand).
// ----------------------------------------------------------------------------
`ifndef RLE_EXPAND_DEQUANTIZE_TOP_DEFINES_SVH
`define RLE_EXPAND_DEQUANTIZE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rled_pkg.sv -----
// ----------------------------------------------------------------------------
// rled_pkg
// Widths, register map and stage payload types of the run-length decoder.
// ----------------------------------------------------------------------------
package rled_pkg;

    localparam int MAX_RUN     = 64;
    localparam int VAL_W       = 8;
    localparam int CNT_W       = 7;
    localparam int SUM_W       = VAL_W + 1;
    localparam int DIV_STEPS   = 3;   // quotient bits resolved per divider stage
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register index (paddr[2]) of the configuration registers
    localparam logic [0:0] REG_QUANT_STEP = 1'b0;

    localparam logic [VAL_W-1:0] QUANT_STEP_RESET = 8'd1;
    localparam logic [CNT_W-1:0] MAX_RUN_CNT      = 7'(MAX_RUN);

    // item moving through the divider stages
    typedef struct packed {
        logic [SUM_W-1:0] dvd;    // dividend bits not yet consumed, MSB first
        logic [VAL_W-1:0] rem;    // partial remainder
        logic [SUM_W-1:0] quo;    // quotient bits so far
        logic [VAL_W-1:0] step;   // effective step, never zero
        logic [CNT_W-1:0] cnt;    // saturated repeat count
        logic             fin;
    } div_item_t;

    // item handed to the expander
    typedef struct packed {
        logic [VAL_W-1:0] pix;
        logic [CNT_W-1:0] cnt;
        logic             fin;
    } run_item_t;

endpackage

// ----- hw/rtl/rle_expand_dequantize_top.sv -----
// ----------------------------------------------------------------------------
// rle_expand_dequantize_top
// Run-length decoder with dequantization: rounds each run value to a
// multiple of quant_step and repeats it min(run_count, 64) times.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     in_valid / in_stall     run_value, run_count, final_run
//  output    out_valid / out_stall   pixel_byte, run_end, frame_end
//  config    APB write/read          quant_step at byte address 0
//
//  An item passes the input register, three divider stages, the multiply
//  stage and the expander's output register before its first byte shows.
//  Each item then shows min(run_count, 64) bytes, one byte per cycle from
//  the expander while out_stall is low; a zero-count item is dropped there
//  and shows no byte.
//  Reset empties the pipeline and sets quant_step to 1.
//  out_stall holds the shown byte and backs up through every stage.
// ----------------------------------------------------------------------------
module rle_expand_dequantize_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rled_pkg::PADDR_W-1:0]   paddr,
    input  logic [rled_pkg::PDATA_W-1:0]   pwdata,
    output logic [rled_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [rled_pkg::VAL_W-1:0]     run_value,
    input  logic [rled_pkg::CNT_W-1:0]     run_count,
    input  logic                           final_run,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rled_pkg::VAL_W-1:0]     pixel_byte,
    output logic                           run_end,
    output logic                           frame_end
);

    logic [rled_pkg::VAL_W-1:0] quant_step_reg;
    logic [rled_pkg::VAL_W-1:0] quant_step_next;
    logic [0:0]                 reg_index;

    logic                  in_ready;
    logic                  f_valid, d1_valid, d2_valid, d3_valid, s_valid;
    logic                  f_ready, d1_ready, d2_ready, d3_ready, s_ready;
    rled_pkg::div_item_t   f_item, d1_item, d2_item, d3_item;
    rled_pkg::run_item_t   s_item;

    // register file
    assign reg_index = paddr[rled_pkg::PADDR_W-1:rled_pkg::PADDR_W-1];
    assign pready    = 1'b1;

    always_comb
    begin
        quant_step_next = quant_step_reg;
        if (psel && penable && pwrite && reg_index == rled_pkg::REG_QUANT_STEP)
        begin
            quant_step_next = pwdata[rled_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == rled_pkg::REG_QUANT_STEP)
        begin
            prdata = {{(rled_pkg::PDATA_W-rled_pkg::VAL_W){1'b0}}, quant_step_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quant_step_reg <= rled_pkg::QUANT_STEP_RESET;
        end
        else
        begin
            quant_step_reg <= quant_step_next;
        end
    end

    assign in_stall = !in_ready;

    rled_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_ready   (in_ready),
        .run_value  (run_value),
        .run_count  (run_count),
        .final_run  (final_run),
        .quant_step (quant_step_reg),
        .dn_valid   (f_valid),
        .dn_ready   (f_ready),
        .dn_item    (f_item)
    );

    rled_div_stage u_div1
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .up_item  (f_item),
        .dn_valid (d1_valid),
        .dn_ready (d1_ready),
        .dn_item  (d1_item)
    );

    rled_div_stage u_div2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (d1_valid),
        .up_ready (d1_ready),
        .up_item  (d1_item),
        .dn_valid (d2_valid),
        .dn_ready (d2_ready),
        .dn_item  (d2_item)
    );

    rled_div_stage u_div3
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (d2_valid),
        .up_ready (d2_ready),
        .up_item  (d2_item),
        .dn_valid (d3_valid),
        .dn_ready (d3_ready),
        .dn_item  (d3_item)
    );

    rled_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (d3_valid),
        .up_ready (d3_ready),
        .up_item  (d3_item),
        .dn_valid (s_valid),
        .dn_ready (s_ready),
        .dn_item  (s_item)
    );

    rled_expand u_expand
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s_valid),
        .up_ready   (s_ready),
        .up_item    (s_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_byte (pixel_byte),
        .run_end    (run_end),
        .frame_end  (frame_end)
    );

endmodule

// ----- hw/rtl/rled_front.sv -----
// ----------------------------------------------------------------------------
// rled_front
// Input register: rounding offset, step clamp and count saturation.
// ----------------------------------------------------------------------------
module rled_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [rled_pkg::VAL_W-1:0]     run_value,
    input  logic [rled_pkg::CNT_W-1:0]     run_count,
    input  logic                           final_run,
    input  logic [rled_pkg::VAL_W-1:0]     quant_step,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output rled_pkg::div_item_t            dn_item
);

    logic                  valid_reg;
    logic                  valid_next;
    rled_pkg::div_item_t   item_reg;
    rled_pkg::div_item_t   item_next;
    logic [rled_pkg::VAL_W-1:0] step_eff;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        step_eff = (quant_step == '0) ? rled_pkg::VAL_W'(1) : quant_step;
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_ready)
        begin
            valid_next     = up_valid;
            item_next.dvd  = {1'b0, run_value} + {2'b00, step_eff[rled_pkg::VAL_W-1:1]};
            item_next.rem  = '0;
            item_next.quo  = '0;
            item_next.step = step_eff;
            item_next.cnt  = (run_count > rled_pkg::MAX_RUN_CNT) ? rled_pkg::MAX_RUN_CNT
                                                                 : run_count;
            item_next.fin  = final_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ----- hw/rtl/rled_div_stage.sv -----
// ----------------------------------------------------------------------------
// rled_div_stage
// One stage of the restoring divider: resolves DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module rled_div_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  rled_pkg::div_item_t  up_item,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output rled_pkg::div_item_t  dn_item
);

    logic                  valid_reg;
    logic                  valid_next;
    rled_pkg::div_item_t   item_reg;
    rled_pkg::div_item_t   item_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        logic [rled_pkg::VAL_W:0] trial;
        rled_pkg::div_item_t      work;
        trial = '0;
        work  = up_item;
        for (int i = 0; i < rled_pkg::DIV_STEPS; i++)
        begin
            // shift in the next dividend bit, subtract if it fits
            trial = {work.rem, work.dvd[rled_pkg::SUM_W-1]};
            work.dvd = {work.dvd[rled_pkg::SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, work.step})
            begin
                trial    = trial - {1'b0, work.step};
                work.quo = {work.quo[rled_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                work.quo = {work.quo[rled_pkg::SUM_W-2:0], 1'b0};
            end
            work.rem = trial[rled_pkg::VAL_W-1:0];
        end
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_ready)
        begin
            valid_next = up_valid;
            item_next  = work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ----- hw/rtl/rled_scale.sv -----
// ----------------------------------------------------------------------------
// rled_scale
// Multiplies the quotient back by the step; keeps the low byte.
// ----------------------------------------------------------------------------
module rled_scale
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  rled_pkg::div_item_t  up_item,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output rled_pkg::run_item_t  dn_item
);

    logic                  valid_reg;
    logic                  valid_next;
    rled_pkg::run_item_t   item_reg;
    rled_pkg::run_item_t   item_next;
    logic [2*rled_pkg::VAL_W-1:0] prod;

    assign up_ready = !valid_reg || dn_ready;

    // only the low byte survives, so the quotient's top bit drops out
    assign prod = {{rled_pkg::VAL_W{1'b0}}, up_item.quo[rled_pkg::VAL_W-1:0]}
                * {{rled_pkg::VAL_W{1'b0}}, up_item.step};

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (up_ready)
        begin
            valid_next    = up_valid;
            item_next.pix = prod[rled_pkg::VAL_W-1:0];
            item_next.cnt = up_item.cnt;
            item_next.fin = up_item.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ----- hw/rtl/rled_expand.sv -----
// ----------------------------------------------------------------------------
// rled_expand
// Output register and run counter: emits each run byte count times.
// ----------------------------------------------------------------------------
`include "rle_expand_dequantize_top_defines.svh"

module rled_expand
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  rled_pkg::run_item_t          up_item,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rled_pkg::VAL_W-1:0]   pixel_byte,
    output logic                         run_end,
    output logic                         frame_end
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [rled_pkg::CNT_W-1:0]  left_reg;      // bytes still to show after this one
    logic [rled_pkg::CNT_W-1:0]  left_next;
    logic [rled_pkg::VAL_W-1:0]  pix_reg;
    logic [rled_pkg::VAL_W-1:0]  pix_next;
    logic                        fin_reg;
    logic                        fin_next;
    logic                        run_end_reg;
    logic                        run_end_next;
    logic                        frame_end_reg;
    logic                        frame_end_next;
    logic                        take;

    assign take     = valid_reg && !out_stall;
    assign up_ready = !valid_reg || (!out_stall && left_reg == '0);

    always_comb
    begin
        valid_next     = valid_reg;
        left_next      = left_reg;
        pix_next       = pix_reg;
        fin_next       = fin_reg;
        run_end_next   = run_end_reg;
        frame_end_next = frame_end_reg;
        if (take)
        begin
            if (left_reg != '0)
            begin
                // advance within the run
                left_next      = left_reg - rled_pkg::CNT_W'(1);
                run_end_next   = (left_reg == rled_pkg::CNT_W'(1));
                frame_end_next = (left_reg == rled_pkg::CNT_W'(1)) && fin_reg;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        // load a new run; an empty run is dropped here
        if (up_valid && up_ready && up_item.cnt != '0)
        begin
            valid_next     = 1'b1;
            left_next      = up_item.cnt - rled_pkg::CNT_W'(1);
            pix_next       = up_item.pix;
            fin_next       = up_item.fin;
            run_end_next   = (up_item.cnt == rled_pkg::CNT_W'(1));
            frame_end_next = (up_item.cnt == rled_pkg::CNT_W'(1)) && up_item.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg       <= pix_next;
        fin_reg       <= fin_next;
        run_end_reg   <= run_end_next;
        frame_end_reg <= frame_end_next;
    end

    assign out_valid  = valid_reg;
    assign pixel_byte = pix_reg;
    assign run_end    = run_end_reg;
    assign frame_end  = frame_end_reg;

    `RLED_ASSERT_NOW(a_left_needs_valid, left_reg != '0, valid_reg, "bytes left, no item")
    `RLED_ASSERT_NOW(a_no_end_mid_run, valid_reg && left_reg != '0, !run_end_reg, "early run_end")
    `RLED_ASSERT_NOW(a_frame_implies_run, valid_reg && frame_end_reg, run_end_reg, "lone frame_end")
    `RLED_ASSERT_NOW(a_left_bound, 1'b1, left_reg < rled_pkg::MAX_RUN_CNT, "run counter too big")
    `RLED_ASSERT_NEXT(a_run_continues, take && left_reg != '0, valid_reg && $stable(pix_reg), "byte moved")

endmodule

// ----- tb/rle_expand_dequantize_top_tb.sv -----
// ----------------------------------------------------------------------------
// rle_expand_dequantize_top_tb
// Sends run-length pairs through the decoder under several quantization
// steps. A scoreboard predicts every dequantized byte with its run and frame
// flags, and checks each output item in order. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module rle_expand_dequantize_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_RUNS   = 235;
    localparam int  PHASES        = 5;
    localparam int  DRAIN_CYCLES  = 12;
    localparam int  MAX_WAIT      = 13;
    localparam longint CYCLE_LIMIT = 1_500_000;

    typedef struct {
        logic [rled_pkg::VAL_W-1:0] pix;
        logic                       run_end;
        logic                       frame_end;
    } pixel_item_t;

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [rled_pkg::PADDR_W-1:0]   paddr = '0;
    logic [rled_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [rled_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [rled_pkg::VAL_W-1:0]     run_value = '0;
    logic [rled_pkg::CNT_W-1:0]     run_count = '0;
    logic                           final_run = 1'b0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [rled_pkg::VAL_W-1:0]     pixel_byte;
    logic                           run_end;
    logic                           frame_end;

    pixel_item_t                    pending_pixels[$];
    logic [rled_pkg::VAL_W-1:0]     model_quant_step = rled_pkg::QUANT_STEP_RESET;
    bit                             tx_idle_on = 1'b1;
    bit                             rx_idle_on = 1'b1;
    int                             error_count = 0;
    int                             stall_left = 0;
    longint                         cycle_count = 0;

    rle_expand_dequantize_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .run_value  (run_value),
        .run_count  (run_count),
        .final_run  (final_run),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_byte (pixel_byte),
        .run_end    (run_end),
        .frame_end  (frame_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Round to the nearest multiple of the step; the product keeps 8 bits.
    function automatic logic [rled_pkg::VAL_W-1:0] dequantize(
        logic [rled_pkg::VAL_W-1:0] v,
        logic [rled_pkg::VAL_W-1:0] q);
        int unsigned step;
        int unsigned sum;
        int unsigned prod;
        step = (q == 0) ? 1 : q;
        sum  = v + (step >> 1);
        prod = (sum / step) * step;
        return prod[rled_pkg::VAL_W-1:0];
    endfunction

    task automatic queue_run_pixels(logic [rled_pkg::VAL_W-1:0] v,
                                    logic [rled_pkg::CNT_W-1:0] c,
                                    logic f);
        int unsigned n;
        pixel_item_t px;
        n = (c > rled_pkg::MAX_RUN) ? rled_pkg::MAX_RUN : c;
        px.pix = dequantize(v, model_quant_step);
        for (int i = 0; i < n; i++)
        begin
            px.run_end   = (i == n - 1);
            px.frame_end = (i == n - 1) && f;
            pending_pixels.push_back(px);
        end
    endtask

    task automatic send_run(logic [rled_pkg::VAL_W-1:0] v,
                            logic [rled_pkg::CNT_W-1:0] c, logic f);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        run_value <= v;
        run_count <= c;
        final_run <= f;
        do @(posedge clk); while (in_stall);
        queue_run_pixels(v, c, f);
    endtask

    // Drop valid, then wait until every predicted byte has come out.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_quant_step(logic [rled_pkg::VAL_W-1:0] q);
        wait_until_drained();
        // zero-count items leave no trace in the queue but may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rled_pkg::REG_QUANT_STEP, 2'b00};
        pwdata  <= rled_pkg::PDATA_W'(q);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_quant_step = q;
    endtask

    function automatic logic [rled_pkg::CNT_W-1:0] draw_run_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 80)
            return rled_pkg::CNT_W'($urandom_range(1, 6));
        else if (r < 95)
            return rled_pkg::CNT_W'($urandom_range(7, rled_pkg::MAX_RUN));
        else
            return rled_pkg::CNT_W'($urandom_range(rled_pkg::MAX_RUN + 1, 127));
    endfunction

    // Stall generator and output checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected output item: pixel_byte %0d", pixel_byte);
                    error_count++;
                end
                else
                begin
                    pixel_item_t exp_px;
                    exp_px = pending_pixels.pop_front();
                    if (pixel_byte !== exp_px.pix)
                    begin
                        $error("pixel_byte: expected %0d, got %0d", exp_px.pix, pixel_byte);
                        error_count++;
                    end
                    if (run_end !== exp_px.run_end)
                    begin
                        $error("run_end: expected %0d, got %0d", exp_px.run_end, run_end);
                        error_count++;
                    end
                    if (frame_end !== exp_px.frame_end)
                    begin
                        $error("frame_end: expected %0d, got %0d",
                               exp_px.frame_end, frame_end);
                        error_count++;
                    end
                end
                stall_left = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left != 0);
        end
    end

    task automatic test_field_extremes();
        send_run(8'd0,   7'd1,  1'b0);
        send_run(8'd255, 7'd1,  1'b1);
        send_run(8'd170, 7'd2,  1'b1);
        send_run(8'd85,  7'd3,  1'b0);
        send_run(8'd42,  7'd0,  1'b1);     // empty final run
        send_run(8'd17,  7'd64, 1'b1);
        send_run(8'd200, 7'd65, 1'b0);     // saturates to a full run
        send_run(8'd99,  7'd127, 1'b1);
    endtask

    task automatic test_rounding_and_wrap();
        write_quant_step(8'd0);            // behaves as a step of one
        send_run(8'd201, 7'd2, 1'b0);
        write_quant_step(8'd2);
        send_run(8'd255, 7'd1, 1'b1);      // rounds to 256, wraps to zero
        send_run(8'd3,   7'd1, 1'b0);
        write_quant_step(8'd3);
        send_run(8'd254, 7'd2, 1'b0);
        send_run(8'd255, 7'd1, 1'b1);
        write_quant_step(8'd128);
        send_run(8'd255, 7'd1, 1'b0);      // wraps
        send_run(8'd63,  7'd1, 1'b0);
        send_run(8'd64,  7'd1, 1'b1);
        write_quant_step(8'd255);
        send_run(8'd127, 7'd1, 1'b0);
        send_run(8'd128, 7'd1, 1'b0);
        send_run(8'd255, 7'd2, 1'b1);
        send_run(8'd0,   7'd0, 1'b0);
    endtask

    task automatic test_pause_until_drained();
        write_quant_step(8'd10);
        for (int i = 0; i < 6; i++)
        begin
            send_run(8'($urandom()), rled_pkg::CNT_W'($urandom_range(1, 8)),
                     1'($urandom()));
            if (i == 2)
                wait_until_drained();
        end
    endtask

    task automatic test_random_runs();
        logic [rled_pkg::VAL_W-1:0] q;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: q = rled_pkg::VAL_W'($urandom_range(2, 15));
                1: q = 8'd255;
                2: q = rled_pkg::VAL_W'($urandom_range(16, 254));
                3: q = 8'd1;
                default: q = rled_pkg::VAL_W'($urandom_range(0, 255));
            endcase
            write_quant_step(q);
            tx_idle_on = (ph != 1);
            rx_idle_on = (ph != 1) && (ph != 3);
            for (int i = 0; i < RANDOM_RUNS / PHASES; i++)
                send_run(rled_pkg::VAL_W'($urandom()), draw_run_count(),
                         ($urandom_range(0, 3) == 0));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_rounding_and_wrap();
        test_pause_until_drained();
        test_random_runs();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
